@@ sv/itd_pkg.sv @@
// Shared types and character constants for the integer to ASCII converter.
package itd_pkg;

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_NINE  = 7'h39;
  localparam logic [6:0] CHAR_A     = 7'h61;
  localparam logic [6:0] CHAR_F     = 7'h66;
  localparam logic [6:0] CHAR_MINUS = 7'h2D;
  localparam logic [3:0] DEC_RADIX  = 4'd10;

  typedef struct packed {
    logic load;         // take a new value from the input channel
    logic conv_step;    // one shift-and-adjust step of the binary to BCD conversion
    logic digit_shift;  // drop the top digit of the digit register
    logic out_load;     // write the output register
    logic out_sign;     // output register gets the minus sign instead of a digit
    logic out_last;     // the character written is the final one
  } itd_cmd_t;

  typedef struct packed {
    logic neg;          // the value being printed is negative
    logic top_zero;     // the top digit of the digit register is zero
  } itd_stat_t;

  function automatic logic [6:0] digit_ascii(input logic [3:0] d);
    logic [6:0] code;
    if (d < DEC_RADIX) begin
      code = CHAR_ZERO + {3'b000, d};
    end else begin
      code = CHAR_A + {3'b000, d - DEC_RADIX};
    end
    return code;
  endfunction

endpackage

@@ sv/integer_to_ascii_digits_top.sv @@
// Integer to ASCII converter: one binary value in, its decimal or hex text out, one
// character per transfer. A value is accepted, then put through VALUE_WIDTH steps of
// shift-and-add-3 BCD conversion in decimal (none in hex); then leading zeros of the
// digit register are dropped, the leading-zero skip is left, a minus sign is sent for a
// negative value and the remaining digits are sent, while out_stall can hold the sign and
// digits. The input is taken again once the last character is in the output register,
// which holds it while the next value starts.
module integer_to_ascii_digits_top import itd_pkg::*; #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_value_bits,
  input  logic        in_use_hex,
  input  logic        in_signed_mode,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  out_char_code,
  output logic        out_last_char
);

  localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
  localparam int NUM_DIGITS = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;

  itd_cmd_t  cmd;
  itd_stat_t stat;

  itd_ctrl #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NUM_DIGITS  (NUM_DIGITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_use_hex (in_use_hex),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  itd_dp #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NUM_DIGITS  (NUM_DIGITS)
  ) u_dp (
    .clk            (clk),
    .in_value       (in_value_bits[VALUE_WIDTH-1:0]),
    .in_use_hex     (in_use_hex),
    .in_signed_mode (in_signed_mode),
    .cmd            (cmd),
    .stat           (stat),
    .char_code      (out_char_code),
    .last_char      (out_last_char)
  );

endmodule

@@ sv/itd_dp.sv @@
// Datapath: magnitude register, digit register with BCD conversion, output register.
module itd_dp import itd_pkg::*; #(
  parameter int VALUE_WIDTH = 64,
  parameter int NUM_DIGITS  = 20
) (
  input  logic                   clk,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic                   in_use_hex,
  input  logic                   in_signed_mode,
  input  itd_cmd_t               cmd,
  output itd_stat_t              stat,
  output logic [6:0]             char_code,
  output logic                   last_char
);

  localparam int DW = NUM_DIGITS * 4;

  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic [DW-1:0]          digits_r, digits_nxt;
  logic                   neg_r, neg_nxt;
  logic [6:0]             char_r, char_nxt;
  logic                   last_r, last_nxt;
  logic [DW-1:0]          adjusted;
  logic [VALUE_WIDTH-1:0] load_mag;
  logic                   load_neg;
  logic [3:0]             top_digit;

  assign top_digit = digits_r[DW-1 -: 4];
  assign load_neg  = in_signed_mode & in_value[VALUE_WIDTH-1];
  assign load_mag  = load_neg ? (~in_value) + {{(VALUE_WIDTH-1){1'b0}}, 1'b1} : in_value;

  // Shift-and-add-3: every BCD digit of five or more is raised by three before the shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (digits_r[i*4 +: 4] >= 4'd5) begin
        adjusted[i*4 +: 4] = digits_r[i*4 +: 4] + 4'd3;
      end else begin
        adjusted[i*4 +: 4] = digits_r[i*4 +: 4];
      end
    end
  end

  always_comb begin
    mag_nxt    = mag_r;
    digits_nxt = digits_r;
    neg_nxt    = neg_r;
    if (cmd.load) begin
      mag_nxt    = load_mag;
      neg_nxt    = load_neg;
      digits_nxt = '0;
      if (in_use_hex) begin
        digits_nxt[VALUE_WIDTH-1:0] = load_mag;
      end
    end else if (cmd.conv_step) begin
      mag_nxt    = {mag_r[VALUE_WIDTH-2:0], 1'b0};
      digits_nxt = {adjusted[DW-2:0], mag_r[VALUE_WIDTH-1]};
    end else if (cmd.digit_shift) begin
      digits_nxt = {digits_r[DW-5:0], 4'd0};
    end
  end

  always_comb begin
    char_nxt = char_r;
    last_nxt = last_r;
    if (cmd.out_load) begin
      char_nxt = cmd.out_sign ? CHAR_MINUS : digit_ascii(top_digit);
      last_nxt = cmd.out_last;
    end
  end

  always_ff @(posedge clk) begin
    mag_r    <= mag_nxt;
    digits_r <= digits_nxt;
    neg_r    <= neg_nxt;
    char_r   <= char_nxt;
    last_r   <= last_nxt;
  end

  assign stat.neg      = neg_r;
  assign stat.top_zero = (top_digit == 4'd0);
  assign char_code     = char_r;
  assign last_char     = last_r;

endmodule

@@ sv/itd_ctrl.sv @@
// Controller: sequences conversion, leading-zero skip, sign and digit output.
module itd_ctrl import itd_pkg::*; #(
  parameter int VALUE_WIDTH = 64,
  parameter int NUM_DIGITS  = 20
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_use_hex,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  itd_stat_t stat,
  output itd_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SKIP = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  localparam int CCW = $clog2(VALUE_WIDTH);
  localparam int DCW = $clog2(NUM_DIGITS + 1);

  logic [2:0]     state_r, state_nxt;
  logic [CCW-1:0] conv_cnt_r, conv_cnt_nxt;
  logic [DCW-1:0] dig_cnt_r, dig_cnt_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           out_free;
  logic           one_left;

  assign out_free = !out_valid_r || !out_stall;
  assign one_left = (dig_cnt_r == DCW'(1));

  always_comb begin
    state_nxt    = state_r;
    conv_cnt_nxt = conv_cnt_r;
    dig_cnt_nxt  = dig_cnt_r;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load     = 1'b1;
          dig_cnt_nxt  = DCW'(NUM_DIGITS);
          conv_cnt_nxt = CCW'(VALUE_WIDTH - 1);
          state_nxt    = in_use_hex ? ST_SKIP : ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
        conv_cnt_nxt  = conv_cnt_r - CCW'(1);
        if (conv_cnt_r == '0) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // A zero value keeps its last digit, which then prints as a single zero.
        if (stat.top_zero && !one_left) begin
          cmd.digit_shift = 1'b1;
          dig_cnt_nxt     = dig_cnt_r - DCW'(1);
        end else begin
          state_nxt = stat.neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sign = 1'b1;
          state_nxt    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_last    = one_left;
          cmd.digit_shift = 1'b1;
          dig_cnt_nxt     = dig_cnt_r - DCW'(1);
          if (one_left) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      conv_cnt_r  <= '0;
      dig_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      conv_cnt_r  <= conv_cnt_nxt;
      dig_cnt_r   <= dig_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ sv/itd_checker.sv @@
// Port-level checker for the integer to ASCII converter, bound to the top level.
module itd_checker import itd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [63:0] in_value_bits,
  input logic        in_use_hex,
  input logic        in_signed_mode,
  input logic        out_valid,
  input logic        out_stall,
  input logic [6:0]  out_char_code,
  input logic        out_last_char
);

  // A held result keeps its character and marker.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char_code) && $stable(out_last_char))
    else $error("held result changed");

  // The block works on one value at a time, so it stalls right after an input transfer.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

  // Only digits, lower-case hex letters and the minus sign are ever sent.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_code >= CHAR_ZERO && out_char_code <= CHAR_NINE) ||
                  (out_char_code >= CHAR_A && out_char_code <= CHAR_F) ||
                  (out_char_code == CHAR_MINUS))
    else $error("illegal character code");

  // A minus sign is always followed by digits.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_code == CHAR_MINUS |-> !out_last_char)
    else $error("minus sign marked as last");

endmodule

bind integer_to_ascii_digits_top itd_checker u_itd_checker (.*);
